FILE: rtl/ihb_pkg.sv
// Shared types and constants for the IPv4 header builder.
// No dependencies; every other file refers to it by scoped names.

package ihb_pkg;

    localparam int HDR_WORDS = 5;
    localparam int IDX_W     = 3;

    localparam logic [IDX_W-1:0] LAST_IDX  = 3'd4;
    localparam logic [15:0]      HDR_BYTES = 16'd20;
    localparam logic [7:0]       VER_IHL   = 8'h45;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IFACE_ADDR = 2'd0;
    localparam logic [1:0] CFG_LINK_MTU   = 2'd1;
    localparam logic [1:0] CFG_CSUM_EN    = 2'd2;

    typedef struct packed {
        logic [31:0] interface_address;
        logic [15:0] link_mtu;
        logic        checksum_enable;
    } cfg_t;

    typedef struct packed {
        logic [15:0] payload_length;
        logic [7:0]  protocol_number;
        logic [7:0]  type_of_service;
        logic [7:0]  time_to_live;
        logic [31:0] dest_address;
        logic [31:0] source_address;
        logic        substitute_source;
    } req_t;

    typedef struct packed {
        logic [HDR_WORDS-1:0][31:0] words;
        logic                       needs_fragment;
    } hdr_t;

endpackage

FILE: rtl/ihb_cfg.sv
// Configuration register file for the IPv4 header builder.
// Depends on ihb_pkg for the register indexes and the cfg_t type.

module ihb_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_addr,
    input  logic [31:0]         cfg_wdata,
    output ihb_pkg::cfg_t       cfg
);

    ihb_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interface_address <= 32'd0;
            cfg_reg.link_mtu          <= 16'd0;
            cfg_reg.checksum_enable   <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                ihb_pkg::CFG_IFACE_ADDR: cfg_reg.interface_address <= cfg_wdata;
                ihb_pkg::CFG_LINK_MTU:   cfg_reg.link_mtu          <= cfg_wdata[15:0];
                ihb_pkg::CFG_CSUM_EN:    cfg_reg.checksum_enable   <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/ihb_build.sv
// Request register, identification counter and header/checksum logic.
// Depends on ihb_pkg for the request, configuration and header types.

module ihb_build
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [103:0]        s_axis_tdata,
    input  logic                s_axis_tuser,
    input  ihb_pkg::cfg_t       cfg,
    output logic                hdr_valid,
    input  logic                hdr_ready,
    output ihb_pkg::hdr_t       hdr
);

    ihb_pkg::req_t req_reg;
    logic          req_valid_reg;
    logic [15:0]   ident_reg;

    logic          take;
    logic          load;
    logic [31:0]   src;
    logic [15:0]   total;
    logic [19:0]   sum;
    logic [16:0]   fold1;
    logic [16:0]   fold2;
    logic [15:0]   csum;

    assign load          = req_valid_reg && hdr_ready;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !req_valid_reg || hdr_ready;
    assign hdr_valid     = req_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            ident_reg     <= 16'd0;
        end
        else
        begin
            if (take)
            begin
                req_valid_reg <= 1'b1;
            end
            else if (load)
            begin
                req_valid_reg <= 1'b0;
            end
            if (load)
            begin
                ident_reg <= ident_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg.source_address    <= s_axis_tdata[31:0];
            req_reg.dest_address      <= s_axis_tdata[63:32];
            req_reg.time_to_live      <= s_axis_tdata[71:64];
            req_reg.type_of_service   <= s_axis_tdata[79:72];
            req_reg.protocol_number   <= s_axis_tdata[87:80];
            req_reg.payload_length    <= s_axis_tdata[103:88];
            req_reg.substitute_source <= s_axis_tuser;
        end
    end

    always_comb
    begin
        if (req_reg.substitute_source && (req_reg.source_address == 32'd0))
        begin
            src = cfg.interface_address;
        end
        else
        begin
            src = req_reg.source_address;
        end

        total = req_reg.payload_length + ihb_pkg::HDR_BYTES;

        // Halfwords that are always zero (flags/offset, checksum) are left out.
        sum = {4'd0, ihb_pkg::VER_IHL, req_reg.type_of_service}
            + {4'd0, total}
            + {4'd0, ident_reg}
            + {4'd0, req_reg.time_to_live, req_reg.protocol_number}
            + {4'd0, src[31:16]}
            + {4'd0, src[15:0]}
            + {4'd0, req_reg.dest_address[31:16]}
            + {4'd0, req_reg.dest_address[15:0]};
        fold1 = {13'd0, sum[19:16]} + {1'b0, sum[15:0]};
        fold2 = {16'd0, fold1[16]} + {1'b0, fold1[15:0]};
        csum  = ~fold2[15:0];

        hdr.words[0] = {ihb_pkg::VER_IHL, req_reg.type_of_service, total};
        hdr.words[1] = {ident_reg, 16'd0};
        hdr.words[2] = {req_reg.time_to_live, req_reg.protocol_number,
                        cfg.checksum_enable ? csum : 16'd0};
        hdr.words[3] = src;
        hdr.words[4] = req_reg.dest_address;
        hdr.needs_fragment = (cfg.link_mtu != 16'd0) && (total > cfg.link_mtu);
    end

    a_ident_step: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (ident_reg == 16'($past(ident_reg) + 16'd1)))
        else $error("identification did not advance by one per header");

    a_req_held: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && !hdr_ready) |=> (req_valid_reg && $stable(req_reg)))
        else $error("pending request lost while the output side was busy");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (!req_valid_reg || load))
        else $error("request accepted over an unconsumed request");

endmodule

FILE: rtl/ihb_serial.sv
// Header holding register and word sequencer for the output stream.
// Depends on ihb_pkg for the header type and word count constants.

module ihb_serial
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       hdr_valid,
    output logic                       hdr_ready,
    input  ihb_pkg::hdr_t              hdr,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [31:0]                m_axis_tdata,
    output logic [3:0]                 m_axis_tuser,
    output logic                       m_axis_tlast
);

    ihb_pkg::hdr_t                 hdr_reg;
    logic                          busy_reg;
    logic [ihb_pkg::IDX_W-1:0]     word_idx_reg;
    logic                          last;
    logic                          send;
    logic                          load;

    assign last      = (word_idx_reg == ihb_pkg::LAST_IDX);
    assign send      = busy_reg && m_axis_tready;
    assign hdr_ready = !busy_reg || (m_axis_tready && last);
    assign load      = hdr_valid && hdr_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            word_idx_reg <= '0;
        end
        else if (load)
        begin
            busy_reg     <= 1'b1;
            word_idx_reg <= '0;
        end
        else if (send)
        begin
            if (last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                word_idx_reg <= word_idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hdr_reg <= hdr;
        end
    end

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = hdr_reg.words[word_idx_reg];
    assign m_axis_tuser  = {hdr_reg.needs_fragment, word_idx_reg};
    assign m_axis_tlast  = last;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (word_idx_reg <= ihb_pkg::LAST_IDX))
        else $error("word index beyond the last header word");

    a_start_word0: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (busy_reg && (word_idx_reg == '0)))
        else $error("new header did not start at word zero");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (send && last && !hdr_valid) |=> !busy_reg)
        else $error("output still valid after the last word with nothing pending");

endmodule

FILE: rtl/ipv4_header_builder.sv
// IPv4 header builder: one request in, five big-endian 32-bit header words out.
// The request is registered in ihb_build, then the header in ihb_serial, before the first word.
// Throughput: one word per cycle while m_axis_tready is high, set by the single-word
// output channel; a new request is taken while words drain.
// Reset clears all valid state and the identification counter, and sets the
// configuration to address 0, MTU 0 and checksum enabled.

module ipv4_header_builder
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_addr,
    input  logic [31:0]   cfg_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // source_address, dest_address, time_to_live, type_of_service,
    // protocol_number, payload_length
    input  logic [103:0]  s_axis_tdata,
    // substitute_source
    input  logic          s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // header_word
    output logic [31:0]   m_axis_tdata,
    // word_index, needs_fragment
    output logic [3:0]    m_axis_tuser,
    output logic          m_axis_tlast
);

    ihb_pkg::cfg_t cfg;
    ihb_pkg::hdr_t hdr;
    logic          hdr_valid;
    logic          hdr_ready;

    ihb_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ihb_build u_build
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg           (cfg),
        .hdr_valid     (hdr_valid),
        .hdr_ready     (hdr_ready),
        .hdr           (hdr)
    );

    ihb_serial u_serial
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .hdr_valid     (hdr_valid),
        .hdr_ready     (hdr_ready),
        .hdr           (hdr),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
